// ----- design/qlt_pkg.sv -----
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types, constants and helpers for the Q-learning table step block.
// ----------------------------------------------------------------------------
package qlt_pkg;

    localparam int DEF_NUM_STATES  = 128;
    localparam int DEF_NUM_ACTIONS = 4;

    localparam int Q_W    = 24;
    localparam int OPND_W = 26;
    localparam int RATE_W = 9;
    localparam int CFG_IDX_W = 2;

    localparam int STATE_IN_W  = 7;
    localparam int REWARD_W    = 8;
    localparam int DRAW_W      = 8;
    localparam int RAND_ACT_W  = 2;
    localparam int OUT_ACT_W   = 2;
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 8;

    localparam logic [RATE_W-1:0] RATE_ONE = 9'd256;

    localparam logic [RATE_W-1:0] LEARN_RATE_RST    = 9'd256;
    localparam logic [RATE_W-1:0] DISCOUNT_RST      = 9'd128;
    localparam logic [RATE_W-1:0] EXPLORE_LEVEL_RST = 9'd230;

    localparam logic [CFG_IDX_W-1:0] REG_LEARN_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_LEVEL = 2'd2;

    localparam logic signed [Q_W:0] Q_MAX = 25'sd8388607;
    localparam logic signed [Q_W:0] Q_MIN = -25'sd8388608;

    typedef logic signed [Q_W-1:0]    q_value_t;
    typedef logic signed [OPND_W-1:0] opnd_t;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] rate;
        opnd_t             operand;
    } scale_req_t;

    function automatic logic [RATE_W-1:0] rate_sat(input logic [RATE_W-1:0] r);
        return (r > RATE_ONE) ? RATE_ONE : r;
    endfunction

    // Reduce a 7-bit index by a constant modulus with restoring steps.
    function automatic logic [9:0] reduce_mod(input logic [STATE_IN_W-1:0] value,
                                               input int unsigned modulus);
        logic [17:0] rem;
        logic [17:0] step;
        rem = {11'b0, value};
        for (int k = STATE_IN_W - 1; k >= 0; k--)
        begin
            step = 18'(modulus) << k;
            if (rem >= step)
            begin
                rem = rem - step;
            end
        end
        return rem[9:0];
    endfunction

endpackage

// ----- design/qlt_ram.sv -----
// ----------------------------------------------------------------------------
// qlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module qlt_ram #(
    parameter int DATA_W = 24,
    parameter int DEPTH  = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/qlt_scale.sv -----
// ----------------------------------------------------------------------------
// qlt_scale
// Shared scaling unit: floor(rate * operand / 256); the operands are registered, then the product.
// ----------------------------------------------------------------------------
module qlt_scale (
    input  logic                clk,
    input  qlt_pkg::scale_req_t req,
    output qlt_pkg::opnd_t      result
);

    localparam int PROD_W = qlt_pkg::OPND_W + qlt_pkg::RATE_W + 1;

    logic [qlt_pkg::RATE_W-1:0] rate_reg;
    qlt_pkg::opnd_t             opnd_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rate_reg <= req.rate;
            opnd_reg <= req.operand;
        end
        prod_reg <= $signed({1'b0, rate_reg}) * opnd_reg;
    end

    // drop the low byte: arithmetic shift floors toward minus infinity
    assign result = prod_reg[qlt_pkg::OPND_W+7:8];

endmodule

// ----- design/q_learning_table_step.sv -----
// ----------------------------------------------------------------------------
// q_learning_table_step
// Tabular Q-learning update with epsilon-greedy action selection.
// ----------------------------------------------------------------------------
// After reset the block clears its Q table, one entry per cycle, all
// NUM_STATES*NUM_ACTIONS entries (512 at the defaults) before s_tready rises;
// configuration writes are taken throughout. Between one acceptance and the
// next, each transaction makes one table read per action to find the row
// maximum, one read of the previous entry, two passes through the shared
// multiplier and a write. When the greedy choice is needed and the previous
// state equals the current one, the row is scanned again after the write. The
// first transaction after reset skips the update.
// The result waits in an output register, so a stalled m_tready only blocks
// the following item once its result is ready.
// ----------------------------------------------------------------------------
module q_learning_table_step #(
    parameter int NUM_STATES  = qlt_pkg::DEF_NUM_STATES,
    parameter int NUM_ACTIONS = qlt_pkg::DEF_NUM_ACTIONS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qlt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [qlt_pkg::RATE_W-1:0]      cfg_data,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // current_state[6:0], reward[14:7], explore_draw[22:15], random_action[24:23]
    input  logic [qlt_pkg::S_TDATA_W-1:0]   s_tdata,
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // chosen_action[1:0]
    output logic [qlt_pkg::M_TDATA_W-1:0]   m_tdata,
    // explored[0]
    output logic                            m_tuser
);

    localparam int SW     = $clog2(NUM_STATES);
    localparam int ACT_W  = $clog2(NUM_ACTIONS);
    localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
    localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(NUM_ACTIONS);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

    typedef enum logic [9:0] {
        ST_CLEAR  = 10'b0000000001,
        ST_IDLE   = 10'b0000000010,
        ST_SCAN   = 10'b0000000100,
        ST_OLD    = 10'b0000001000,
        ST_MULA   = 10'b0000010000,
        ST_DIFF   = 10'b0000100000,
        ST_MULB   = 10'b0001000000,
        ST_WRITE  = 10'b0010000000,
        ST_RESCAN = 10'b0100000000,
        ST_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [qlt_pkg::RATE_W-1:0] learn_rate_reg;
    logic [qlt_pkg::RATE_W-1:0] discount_reg;
    logic [qlt_pkg::RATE_W-1:0] explore_level_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic [SW-1:0]                     s_reg;
    logic signed [qlt_pkg::REWARD_W-1:0] reward_reg;
    logic [qlt_pkg::DRAW_W-1:0]        draw_reg;
    logic [ACT_W-1:0]                  rnd_reg;

    logic [SW-1:0]    prev_state_reg;
    logic [ACT_W-1:0] prev_action_reg;
    logic             has_prev_reg;

    logic             rd_valid_reg;
    logic [ACT_W-1:0] rd_act_reg;
    qlt_pkg::q_value_t best_reg;
    logic [ACT_W-1:0]  arg_reg;
    qlt_pkg::q_value_t old_reg;

    logic                     m_tvalid_reg;
    logic [qlt_pkg::OUT_ACT_W-1:0] m_action_reg;
    logic                     m_explored_reg;

    logic               s_accept;
    logic               scanning;
    logic               issue_read;
    logic [ADDR_W-1:0]  row_base;
    logic [ADDR_W-1:0]  prev_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [qlt_pkg::Q_W-1:0] wr_data;
    logic [qlt_pkg::Q_W-1:0] rd_data;

    qlt_pkg::scale_req_t scale_req;
    qlt_pkg::opnd_t      scale_result;
    qlt_pkg::opnd_t      target;
    qlt_pkg::opnd_t      diff;
    logic signed [qlt_pkg::Q_W+2:0] sum;
    qlt_pkg::q_value_t   q_new;

    logic [9:0]         explore_sum;
    logic               explore_hit;
    logic [ACT_W-1:0]   action_pick;
    logic               out_free;
    logic               need_rescan;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign scanning   = (state_reg == ST_SCAN) || (state_reg == ST_RESCAN);
    assign issue_read = scanning && (cnt_reg != CNT_LAST);

    assign row_base  = ADDR_W'(s_reg * NUM_ACTIONS);
    assign prev_addr = ADDR_W'(prev_state_reg * NUM_ACTIONS) + ADDR_W'(prev_action_reg);

    always_comb
    begin
        if (issue_read)
        begin
            rd_addr = row_base + ADDR_W'(cnt_reg);
        end
        else
        begin
            rd_addr = prev_addr;
        end
    end

    assign explore_sum = {2'b0, draw_reg}
                         + {1'b0, qlt_pkg::rate_sat(explore_level_reg)};
    assign explore_hit = explore_sum > {1'b0, qlt_pkg::RATE_ONE};
    assign action_pick = explore_hit ? rnd_reg : arg_reg;
    assign need_rescan = !explore_hit && (prev_state_reg == s_reg);

    // update arithmetic
    assign target = (qlt_pkg::OPND_W'(reward_reg) <<< 8) + scale_result;
    assign diff   = target - qlt_pkg::OPND_W'(old_reg);
    assign sum    = (qlt_pkg::Q_W+3)'(old_reg) + (qlt_pkg::Q_W+3)'(scale_result);

    always_comb
    begin
        if (sum > (qlt_pkg::Q_W+3)'(qlt_pkg::Q_MAX))
        begin
            q_new = qlt_pkg::Q_W'(qlt_pkg::Q_MAX);
        end
        else if (sum < (qlt_pkg::Q_W+3)'(qlt_pkg::Q_MIN))
        begin
            q_new = qlt_pkg::Q_W'(qlt_pkg::Q_MIN);
        end
        else
        begin
            q_new = sum[qlt_pkg::Q_W-1:0];
        end
    end

    always_comb
    begin
        scale_req.start   = 1'b0;
        scale_req.rate    = qlt_pkg::rate_sat(discount_reg);
        scale_req.operand = qlt_pkg::OPND_W'(best_reg);
        if (state_reg == ST_OLD)
        begin
            scale_req.start = 1'b1;
        end
        else if (state_reg == ST_DIFF)
        begin
            scale_req.start   = 1'b1;
            scale_req.rate    = qlt_pkg::rate_sat(learn_rate_reg);
            scale_req.operand = diff;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = prev_addr;
        wr_data = q_new;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = '0;
        end
        else if (state_reg == ST_WRITE)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == ADDR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = has_prev_reg ? ST_OLD : ST_DONE;
                end
            end
            ST_OLD:    state_next = ST_MULA;
            ST_MULA:   state_next = ST_DIFF;
            ST_DIFF:   state_next = ST_MULB;
            ST_MULB:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                cnt_next   = '0;
                state_next = need_rescan ? ST_RESCAN : ST_DONE;
            end
            ST_RESCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_CLEAR;
            cnt_reg           <= '0;
            clr_addr_reg      <= '0;
            learn_rate_reg    <= qlt_pkg::LEARN_RATE_RST;
            discount_reg      <= qlt_pkg::DISCOUNT_RST;
            explore_level_reg <= qlt_pkg::EXPLORE_LEVEL_RST;
            prev_state_reg    <= '0;
            prev_action_reg   <= '0;
            has_prev_reg      <= 1'b0;
            rd_valid_reg      <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= issue_read;

            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qlt_pkg::REG_LEARN_RATE:    learn_rate_reg    <= cfg_data;
                    qlt_pkg::REG_DISCOUNT:      discount_reg      <= cfg_data;
                    qlt_pkg::REG_EXPLORE_LEVEL: explore_level_reg <= cfg_data;
                    default:                    ;
                endcase
            end

            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg    <= 1'b1;
                prev_state_reg  <= s_reg;
                prev_action_reg <= action_pick;
                has_prev_reg    <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s_reg      <= SW'(qlt_pkg::reduce_mod(s_tdata[6:0], NUM_STATES));
            reward_reg <= s_tdata[14:7];
            draw_reg   <= s_tdata[22:15];
            rnd_reg    <= ACT_W'(qlt_pkg::reduce_mod({5'b0, s_tdata[24:23]},
                                                     NUM_ACTIONS));
        end

        rd_act_reg <= ACT_W'(cnt_reg);

        // first index wins ties
        if (rd_valid_reg)
        begin
            if ((rd_act_reg == '0) || ($signed(rd_data) > best_reg))
            begin
                best_reg <= rd_data;
                arg_reg  <= rd_act_reg;
            end
        end

        if (state_reg == ST_OLD)
        begin
            old_reg <= rd_data;
        end

        if ((state_reg == ST_DONE) && out_free)
        begin
            m_action_reg   <= qlt_pkg::OUT_ACT_W'(action_pick);
            m_explored_reg <= explore_hit;
        end
    end

    qlt_ram #(
        .DATA_W (qlt_pkg::Q_W),
        .DEPTH  (DEPTH)
    ) u_qlt_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    qlt_scale u_qlt_scale (
        .clk    (clk),
        .req    (scale_req),
        .result (scale_result)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(qlt_pkg::M_TDATA_W - qlt_pkg::OUT_ACT_W){1'b0}}, m_action_reg};
    assign m_tuser  = m_explored_reg;

endmodule
